// ----- design/keyed_quantity_table_top_macros.svh -----
// assertion macros for the keyed quantity table checker
// expects clk and arst_n in the scope of use
`ifndef KEYED_QUANTITY_TABLE_TOP_MACROS_SVH
`define KEYED_QUANTITY_TABLE_TOP_MACROS_SVH

// consequent checked in the same cycle
`define KQT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed quantity table check failed");

// consequent checked in the next cycle
`define KQT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed quantity table check failed");

`endif

// ----- design/kqt_pkg.sv -----
// shared types and codes for the keyed quantity table
// no dependencies
package kqt_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 128;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_SEARCH = 2'd1;
	localparam logic [1:0] FUNC_UPDATE = 2'd2;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_PRESENT   = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] part_key;
		logic signed [31:0] quantity_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] quantity_out;
		logic [6:0]         entry_index;
		logic [7:0]         entries_used;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_DONE
	} state_t;

endpackage

// ----- design/kqt_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module kqt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/keyed_quantity_table_top.sv -----
// keyed quantity table: insert, search and saturating update over a key/quantity table
// depends on kqt_pkg and kqt_ram
// one transaction in flight: the key memory walk reads one stored entry per cycle;
// the result register frees the next accept while it waits
// reset clears the fill count and control, the table reads empty; memories are not cleared
module keyed_quantity_table_top #(
	parameter int unsigned MAX_ENTRIES = kqt_pkg::MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kqt_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output kqt_pkg::out_item_t out_data
);

	localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

	kqt_pkg::state_t state_q, state_d;

	logic [1:0]       func_q;
	logic [31:0]      key_q;
	logic [31:0]      qin_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic             issue_s1;
	logic [1:0]       res_status_q;
	logic [31:0]      res_qty_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             out_valid_q;
	kqt_pkg::out_item_t out_q;

	logic [31:0] key_rd;
	logic [31:0] qty_rd;
	logic        key_we;
	logic        qty_we;
	logic        accept;
	logic        full;
	logic        issue_now;
	logic        scan_hit;
	logic        scan_miss;
	logic        load_out;
	logic [32:0] sum_wide;
	logic [31:0] sum_sat;

	assign accept    = in_valid && in_ready;
	assign full      = (used_q == CNT_W'(MAX_ENTRIES));
	assign issue_now = (rd_idx_q < used_q);
	assign scan_hit  = issue_s1 && (key_rd == key_q);
	assign scan_miss = !issue_s1 && !issue_now;

	// saturating add of the stored quantity and the signed change
	assign sum_wide = {qty_rd[31], qty_rd} + {qin_q[31], qin_q};
	always_comb begin
		if (sum_wide[32] != sum_wide[31]) begin
			sum_sat = sum_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			sum_sat = sum_wide[31:0];
		end
	end

	kqt_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(res_idx_q),
		.wdata(key_q),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(key_rd)
	);

	kqt_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ENTRIES)
	) u_qty_ram (
		.clk  (clk),
		.we   (qty_we),
		.waddr(res_idx_q),
		.wdata(res_qty_q),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(qty_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kqt_pkg::S_IDLE: begin
				if (in_valid) begin
					if (in_data.func == kqt_pkg::FUNC_INSERT && full) begin
						state_d = kqt_pkg::S_DONE;
					end else if (in_data.func == kqt_pkg::FUNC_INSERT ||
						in_data.func == kqt_pkg::FUNC_SEARCH ||
						in_data.func == kqt_pkg::FUNC_UPDATE) begin
						state_d = kqt_pkg::S_SCAN;
					end else begin
						state_d = kqt_pkg::S_DONE;
					end
				end
			end
			kqt_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = (func_q == kqt_pkg::FUNC_UPDATE) ? kqt_pkg::S_WRITE
						: kqt_pkg::S_DONE;
				end else if (scan_miss) begin
					state_d = (func_q == kqt_pkg::FUNC_INSERT) ? kqt_pkg::S_WRITE
						: kqt_pkg::S_DONE;
				end
			end
			kqt_pkg::S_WRITE: begin
				state_d = kqt_pkg::S_DONE;
			end
			kqt_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = kqt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kqt_pkg::S_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		key_we   = 1'b0;
		qty_we   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			kqt_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			kqt_pkg::S_SCAN: begin
			end
			kqt_pkg::S_WRITE: begin
				key_we = (func_q == kqt_pkg::FUNC_INSERT);
				qty_we = 1'b1;
			end
			kqt_pkg::S_DONE: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kqt_pkg::S_IDLE;
			used_q      <= '0;
			issue_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == kqt_pkg::S_SCAN) begin
				issue_s1 <= issue_now;
			end else begin
				issue_s1 <= 1'b0;
			end
			if (state_q == kqt_pkg::S_WRITE && func_q == kqt_pkg::FUNC_INSERT) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q       <= in_data.func;
			key_q        <= $unsigned(in_data.part_key);
			qin_q        <= $unsigned(in_data.quantity_in);
			rd_idx_q     <= '0;
			res_qty_q    <= '0;
			res_idx_q    <= '0;
			res_status_q <= (in_data.func == kqt_pkg::FUNC_INSERT && full)
				? kqt_pkg::STAT_FULL : kqt_pkg::STAT_NOT_FOUND;
		end
		if (state_q == kqt_pkg::S_SCAN) begin
			if (issue_now) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			idx_s1 <= rd_idx_q[IDX_W-1:0];
			if (scan_hit) begin
				if (func_q == kqt_pkg::FUNC_INSERT) begin
					res_status_q <= kqt_pkg::STAT_PRESENT;
				end else begin
					res_status_q <= kqt_pkg::STAT_DONE;
					res_idx_q    <= idx_s1;
					res_qty_q    <= (func_q == kqt_pkg::FUNC_UPDATE) ? sum_sat : qty_rd;
				end
			end else if (scan_miss && func_q == kqt_pkg::FUNC_INSERT) begin
				res_status_q <= kqt_pkg::STAT_DONE;
				res_idx_q    <= used_q[IDX_W-1:0];
				res_qty_q    <= qin_q;
			end
		end
		if (load_out) begin
			out_q.status       <= res_status_q;
			out_q.quantity_out <= $signed(res_qty_q);
			out_q.entry_index  <= 7'(res_idx_q);
			out_q.entries_used <= 8'(used_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- design/kqt_checker.sv -----
// port-level checks for the keyed quantity table, bound to the top level
// depends on kqt_pkg and keyed_quantity_table_top_macros.svh
`include "keyed_quantity_table_top_macros.svh"

module kqt_checker #(
	parameter int unsigned MAX_ENTRIES = kqt_pkg::MAX_ENTRIES_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input kqt_pkg::out_item_t out_data
);

	// a stalled result holds
	`KQT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// one transaction at a time: busy right after an accept
	`KQT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// failed operations report no entry and no quantity
	`KQT_ASSERT_SAME(a_fail_zero, out_valid && out_data.status != kqt_pkg::STAT_DONE, out_data.quantity_out == 32'sd0 && out_data.entry_index == 7'd0)

	// a full answer only comes with the table at capacity
	`KQT_ASSERT_SAME(a_full_count, out_valid && out_data.status == kqt_pkg::STAT_FULL, out_data.entries_used == 8'(MAX_ENTRIES))

endmodule

bind keyed_quantity_table_top kqt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_kqt_checker (.*);

// ----- dv/keyed_quantity_table_top_test.sv -----
`timescale 1ns / 1ps

// self-checking bench for keyed_quantity_table_top: a directed table of transactions,
// then random traffic, every reply checked against its typed reply or a behavioral model of the table
// depends on kqt_pkg and keyed_quantity_table_top
module keyed_quantity_table_top_test;
	import kqt_pkg::*;

	localparam int unsigned TABLE_DEPTH = MAX_ENTRIES_DEF;
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 750;
	localparam int QUIET_TAIL    = 100;
	localparam int HOLD_AFTER    = 150;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = TABLE_DEPTH + 16;
	localparam int MAX_PRINTED   = 60;
	localparam int DIR_ROWS      = 23;

	typedef struct packed {
		in_item_t  stim;
		logic      typed;
		out_item_t reply;
	} dir_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      out_ready = 1'b0;
	in_item_t  in_data   = '0;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_data;

	// table contents as the block should hold them
	logic signed [31:0] tbl_key [TABLE_DEPTH];
	logic signed [31:0] tbl_qty [TABLE_DEPTH];
	int unsigned        tbl_used = 0;
	out_item_t          table_replies [$];
	out_item_t          want;

	int fail_count  = 0;
	int sent_count  = 0;
	int reply_count = 0;
	int n_stored    = 0;
	int n_hits      = 0;
	int n_misses    = 0;
	int n_full      = 0;
	int n_present   = 0;
	int n_clipped   = 0;
	bit quiet       = 1'b0;

	// typed replies only where they follow directly from the operation
	dir_row_t dir_table [DIR_ROWS] = '{
		'{'{FUNC_SEARCH, 32'sd5, 32'sd0}, 1'b1, '{STAT_NOT_FOUND, 32'sd0, 7'd0, 8'd0}},
		'{'{FUNC_UPDATE, 32'sd5, 32'sd7}, 1'b1, '{STAT_NOT_FOUND, 32'sd0, 7'd0, 8'd0}},
		'{'{FUNC_UNUSED, 32'sd0, 32'sd0}, 1'b1, '{STAT_NOT_FOUND, 32'sd0, 7'd0, 8'd0}},
		'{'{FUNC_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b1,
			'{STAT_DONE, 32'sh7FFF_FFFF, 7'd0, 8'd1}},
		'{'{FUNC_INSERT, 32'sh8000_0000, 32'sh8000_0000}, 1'b1,
			'{STAT_DONE, 32'sh8000_0000, 7'd1, 8'd2}},
		'{'{FUNC_INSERT, 32'sd0, 32'sd0}, 1'b1, '{STAT_DONE, 32'sd0, 7'd2, 8'd3}},
		'{'{FUNC_INSERT, 32'shFFFF_FFFF, 32'shFFFF_FFFF}, 1'b1,
			'{STAT_DONE, 32'shFFFF_FFFF, 7'd3, 8'd4}},
		'{'{FUNC_INSERT, 32'sh7FFF_FFFF, 32'sd5}, 1'b1, '{STAT_PRESENT, 32'sd0, 7'd0, 8'd4}},
		'{'{FUNC_UPDATE, 32'sh7FFF_FFFF, 32'sd1}, 1'b1,
			'{STAT_DONE, 32'sh7FFF_FFFF, 7'd0, 8'd4}},
		'{'{FUNC_UPDATE, 32'sh8000_0000, 32'shFFFF_FFFF}, 1'b1,
			'{STAT_DONE, 32'sh8000_0000, 7'd1, 8'd4}},
		'{'{FUNC_UPDATE, 32'sd0, 32'sh8000_0000}, 1'b1,
			'{STAT_DONE, 32'sh8000_0000, 7'd2, 8'd4}},
		'{'{FUNC_UPDATE, 32'sd0, 32'sh7FFF_FFFF}, 1'b1,
			'{STAT_DONE, 32'shFFFF_FFFF, 7'd2, 8'd4}},
		'{'{FUNC_UPDATE, 32'shFFFF_FFFF, 32'shFFFF_FFFF}, 1'b1,
			'{STAT_DONE, 32'shFFFF_FFFE, 7'd3, 8'd4}},
		'{'{FUNC_SEARCH, 32'shFFFF_FFFF, 32'sd12345}, 1'b0, '0},
		'{'{FUNC_SEARCH, 32'sd12345, 32'sd0}, 1'b1, '{STAT_NOT_FOUND, 32'sd0, 7'd0, 8'd4}},
		'{'{FUNC_UNUSED, 32'shFFFF_FFFF, 32'sd9}, 1'b1,
			'{STAT_NOT_FOUND, 32'sd0, 7'd0, 8'd4}},
		'{'{FUNC_UPDATE, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b1,
			'{STAT_DONE, 32'shFFFF_FFFF, 7'd0, 8'd4}},
		'{'{FUNC_INSERT, 32'shA5A5_A5A5, 32'sh5A5A_5A5A}, 1'b0, '0},
		'{'{FUNC_INSERT, 32'sh5A5A_5A5A, 32'shA5A5_A5A5}, 1'b0, '0},
		'{'{FUNC_UPDATE, 32'shA5A5_A5A5, 32'sh8000_0001}, 1'b0, '0},
		'{'{FUNC_SEARCH, 32'sh5A5A_5A5A, 32'shFFFF_FFFF}, 1'b0, '0},
		'{'{FUNC_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b0, '0},
		'{'{FUNC_SEARCH, 32'sh8000_0000, 32'sd0}, 1'b0, '0}
	};

	keyed_quantity_table_top #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_PRINTED) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	// applies one operation to the table and returns the reply it must produce
	function automatic out_item_t table_apply(input in_item_t it);
		out_item_t          r;
		int                 hit;
		logic signed [32:0] sum;
		r = '0;
		r.status = STAT_NOT_FOUND;
		hit = -1;
		for (int i = 0; i < int'(tbl_used); i++) begin
			if (hit < 0 && tbl_key[i] == it.part_key) begin
				hit = i;
			end
		end
		case (it.func)
			FUNC_INSERT: begin
				// full wins over duplicate
				if (tbl_used >= TABLE_DEPTH) begin
					r.status = STAT_FULL;
					n_full++;
				end else if (hit >= 0) begin
					r.status = STAT_PRESENT;
					n_present++;
				end else begin
					tbl_key[tbl_used] = it.part_key;
					tbl_qty[tbl_used] = it.quantity_in;
					r.status = STAT_DONE;
					r.quantity_out = it.quantity_in;
					r.entry_index = 7'(tbl_used);
					tbl_used++;
					n_stored++;
				end
			end
			FUNC_SEARCH, FUNC_UPDATE: begin
				if (hit >= 0) begin
					if (it.func == FUNC_UPDATE) begin
						sum = {tbl_qty[hit][31], tbl_qty[hit]} +
							{it.quantity_in[31], it.quantity_in};
						// carry out differs from sign bit: clip to the nearer limit
						if (sum[32] != sum[31]) begin
							tbl_qty[hit] = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
							n_clipped++;
						end else begin
							tbl_qty[hit] = sum[31:0];
						end
					end
					r.status = STAT_DONE;
					r.quantity_out = tbl_qty[hit];
					r.entry_index = 7'(hit);
					n_hits++;
				end else begin
					n_misses++;
				end
			end
			default: begin
				n_misses++;
			end
		endcase
		r.entries_used = 8'(tbl_used);
		return r;
	endfunction

	function automatic logic signed [31:0] corner_value();
		case ($urandom_range(0, 4))
			0: return 32'sd0;
			1: return 32'shFFFF_FFFF;
			2: return 32'sd1;
			3: return 32'sh7FFF_FFFF;
			default: return 32'sh8000_0000;
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t    it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (tbl_used < TABLE_DEPTH) begin
			it.func = pick < 50 ? FUNC_INSERT : pick < 70 ? FUNC_SEARCH :
				pick < 95 ? FUNC_UPDATE : FUNC_UNUSED;
		end else begin
			it.func = pick < 15 ? FUNC_INSERT : pick < 50 ? FUNC_SEARCH :
				pick < 95 ? FUNC_UPDATE : FUNC_UNUSED;
		end
		// lookups mostly hit stored keys, inserts mostly bring new ones
		pick = $urandom_range(0, 99);
		if (tbl_used > 0 && pick < (it.func == FUNC_INSERT ? 20 : 75)) begin
			it.part_key = tbl_key[$urandom_range(0, tbl_used - 1)];
		end else if (pick < 90) begin
			it.part_key = $urandom;
		end else begin
			it.part_key = corner_value();
		end
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			it.quantity_in = $urandom;
		end else if (pick < 60) begin
			it.quantity_in = $signed($urandom_range(0, 200)) - 32'sd100;
		end else if (pick < 80) begin
			it.quantity_in = 32'sh7FFF_0000 + $urandom_range(0, 65535);
		end else if (pick < 95) begin
			it.quantity_in = 32'sh8000_0000 + $urandom_range(0, 65535);
		end else begin
			it.quantity_in = corner_value();
		end
		return it;
	endfunction

	// holds the transaction until accepted, then queues its reply
	task automatic offer(input in_item_t it, input logic typed, input out_item_t typed_reply);
		out_item_t r;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		r = table_apply(it);
		table_replies.push_back(typed ? typed_reply : r);
		sent_count++;
	endtask

	task automatic sender_pause();
		int n;
		if (quiet || $urandom_range(0, 3) != 0) begin
			return;
		end
		n = $urandom_range(1, 9);
		in_valid <= 1'b0;
		in_data <= '{func: 2'($urandom), part_key: $urandom, quantity_in: $urandom};
		repeat (n) @(posedge clk);
	endtask

	// receiver: random stalls plus one long hold that backs up the input side
	initial begin
		int idle_left;
		int rx_seen;
		bit held;
		idle_left = 0;
		rx_seen   = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				rx_seen++;
			end
			if (!held && rx_seen >= HOLD_AFTER) begin
				held = 1'b1;
				idle_left = HOLD_CYCLES;
			end
			if (idle_left > 0) begin
				idle_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				idle_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			reply_count++;
			if (table_replies.size() == 0) begin
				report_mismatch($sformatf("reply %0d with nothing pending: %p",
					reply_count, out_data));
			end else begin
				want = table_replies.pop_front();
				if (out_data.status !== want.status) begin
					report_mismatch($sformatf("reply %0d status %0d, want %0d",
						reply_count, out_data.status, want.status));
				end
				if (out_data.quantity_out !== want.quantity_out) begin
					report_mismatch($sformatf("reply %0d quantity %0d, want %0d",
						reply_count, out_data.quantity_out, want.quantity_out));
				end
				if (out_data.entry_index !== want.entry_index) begin
					report_mismatch($sformatf("reply %0d index %0d, want %0d",
						reply_count, out_data.entry_index, want.entry_index));
				end
				if (out_data.entries_used !== want.entries_used) begin
					report_mismatch($sformatf("reply %0d used %0d, want %0d",
						reply_count, out_data.entries_used, want.entries_used));
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_table[i]) begin
			offer(dir_table[i].stim, dir_table[i].typed, dir_table[i].reply);
			sender_pause();
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_TAIL) begin
				quiet = 1'b1;
			end
			offer(random_item(), 1'b0, '0);
			sender_pause();
		end
		in_valid <= 1'b0;
		while (table_replies.size() != 0) begin
			@(posedge clk);
		end
		// a stray extra reply would show up here
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d transactions: %0d stored, %0d found, %0d missed, %0d clipped updates",
			sent_count, n_stored, n_hits, n_misses, n_clipped);
		$display("insert refused %0d times on a full table and %0d times on a present key",
			n_full, n_present);
		if (fail_count == 0) begin
			$display("keyed_quantity_table_top regression: pass");
		end else begin
			$display("keyed_quantity_table_top regression: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout after %0d of %0d replies", reply_count, sent_count);
		$display("keyed_quantity_table_top regression: fail");
		$finish;
	end

endmodule

// ----- keyed_quantity_table_top.f -----
+incdir+design
design/kqt_pkg.sv
design/kqt_ram.sv
design/keyed_quantity_table_top.sv
design/kqt_checker.sv
dv/keyed_quantity_table_top_test.sv
